// ===== sv/mstp_pkg.sv =====
// ---------------------------------------------------------------------------
// mstp_pkg: shared types and constants for the tick timer pool
// Action and status codes, result entry layout, sequencer step numbers and
// the microcode table that drives the timer pool datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mstp_pkg;

	// result buffer sizing (at most eight results per request)
	localparam int unsigned MAX_RES        = 8;
	localparam int unsigned RES_IDX_W      = 3;
	localparam int unsigned RES_CNT_W      = 4;
	localparam int unsigned NUM_SLOT_CODES = 8;

	// request codes
	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_STOP  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOFREE = 2'd1;
	localparam logic [1:0] ST_ZERO   = 2'd2;

	// sequencer step numbers (microcode address)
	typedef logic [2:0] step_t;
	localparam step_t S_IDLE    = 3'd0;
	localparam step_t S_TK_RD   = 3'd1;
	localparam step_t S_TK_UPD  = 3'd2;
	localparam step_t S_TK_FIN  = 3'd3;
	localparam step_t S_ST_SCAN = 3'd4;
	localparam step_t S_SP_CLR  = 3'd5;
	localparam step_t S_OTHER   = 3'd6;
	localparam step_t S_EMIT    = 3'd7;

	// datapath operation selected by a control word
	typedef enum logic [2:0] {
		OP_IDLE     = 3'd0,
		OP_NOP      = 3'd1,
		OP_TICK     = 3'd2,
		OP_TICK_FIN = 3'd3,
		OP_START    = 3'd4,
		OP_STOP     = 3'd5,
		OP_OTHER    = 3'd6,
		OP_EMIT     = 3'd7
	} op_t;

	// branch condition: true takes jmp (dispatch: the entry step), false takes nxt
	typedef enum logic [2:0] {
		C_ALWAYS    = 3'd0,
		C_DISPATCH  = 3'd1,
		C_SLOT_LAST = 3'd2,
		C_SCAN_END  = 3'd3,
		C_EMIT_LAST = 3'd4
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t nxt;
		step_t jmp;
	} ctrl_t;

	// one buffered result
	typedef struct packed {
		logic [1:0] status;
		logic [2:0] slot;
		logic       expired;
		logic [7:0] tag;
	} res_t;

	// control store
	function automatic ctrl_t ucode_rom(input step_t pc);
		ctrl_t w;
		unique case (pc)
			S_IDLE:    w = '{op: OP_IDLE,     cond: C_DISPATCH,  nxt: S_IDLE,    jmp: S_IDLE};
			S_TK_RD:   w = '{op: OP_NOP,      cond: C_ALWAYS,    nxt: S_TK_UPD,  jmp: S_TK_UPD};
			S_TK_UPD:  w = '{op: OP_TICK,     cond: C_SLOT_LAST, nxt: S_TK_RD,   jmp: S_TK_FIN};
			S_TK_FIN:  w = '{op: OP_TICK_FIN, cond: C_ALWAYS,    nxt: S_EMIT,    jmp: S_EMIT};
			S_ST_SCAN: w = '{op: OP_START,    cond: C_SCAN_END,  nxt: S_ST_SCAN, jmp: S_EMIT};
			S_SP_CLR:  w = '{op: OP_STOP,     cond: C_ALWAYS,    nxt: S_EMIT,    jmp: S_EMIT};
			S_OTHER:   w = '{op: OP_OTHER,    cond: C_ALWAYS,    nxt: S_EMIT,    jmp: S_EMIT};
			S_EMIT:    w = '{op: OP_EMIT,     cond: C_EMIT_LAST, nxt: S_EMIT,    jmp: S_IDLE};
		endcase
		return w;
	endfunction

	// entry step for each request code
	function automatic step_t dispatch(input logic [1:0] act);
		step_t s;
		unique case (act)
			ACT_TICK:  s = S_TK_RD;
			ACT_START: s = S_ST_SCAN;
			ACT_STOP:  s = S_SP_CLR;
			default:   s = S_OTHER;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== sv/mstp_ram.sv =====
// ---------------------------------------------------------------------------
// mstp_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mstp_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 8,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/multi_slot_tick_timer_pool_top.sv =====
// Tick: walks every slot in two steps each (read, then update), since count and period
// come from registered RAM reads; start scans slots until a free one, a zero period or
// the last slot; stop or unused code writes one result. Results leave in the emit step.
// Requests: one at a time, the next taken only once the last result has been sent;
// output stalls hold the emit step.
// Reset: arst_n clears active/repeat flags, sequencer and out_valid; slot RAMs kept.
// ---------------------------------------------------------------------------
// multi_slot_tick_timer_pool_top: pool of one-shot and periodic tick timers
// A microcoded sequencer walks the slots for tick and start requests, collects
// results in a small buffer and then sends them out one transfer at a time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multi_slot_tick_timer_pool_top
	import mstp_pkg::*;
#(
	parameter int unsigned NUM_TIMERS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  action,
	input  wire logic [31:0] period_ticks,
	input  wire logic        repeat_mode,
	input  wire logic [7:0]  user_tag,
	input  wire logic [2:0]  target_slot,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [2:0]       slot_index,
	output logic             expired,
	output logic [7:0]       expired_tag,
	output logic             last_result,
	output logic             any_active
);

	localparam int unsigned SLOT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	// sequencer
	step_t pc_q, pc_d;
	ctrl_t ctrl;

	// slot flags and counters
	logic [NUM_TIMERS-1:0] active_q, repeat_q, stop_hit;
	logic [SLOT_W-1:0]     slot_q;
	logic [SLOT_W+2:0]     slot_ext;
	logic [2:0]            slot3;
	logic                  slot_last;

	// latched request
	logic [31:0] period_q;
	logic        rep_q;
	logic [7:0]  tag_q;
	logic [2:0]  target_q;

	// slot storage
	logic        cnt_we, cfg_we;
	logic [31:0] cnt_wdata, cnt_rd, per_rd, cnt_inc;
	logic [7:0]  tag_rd;

	// result buffer
	res_t                 res_q [MAX_RES];
	res_t                 buf_wd, buf_rd;
	logic                 buf_we;
	logic [RES_CNT_W-1:0] n_q;
	logic [RES_IDX_W-1:0] emit_q;
	logic                 emit_fire, emit_last;

	// decode helpers
	logic in_fire, tick_hit, free_here, zero_per, scan_end, claim;

	// output register
	logic       out_valid_q;
	res_t       out_q;
	logic       last_q, any_q;

	assign ctrl     = ucode_rom(pc_q);
	assign in_stall = (ctrl.op != OP_IDLE);
	assign in_fire  = in_valid && !in_stall;

	assign slot_ext  = {3'b000, slot_q};
	assign slot3     = slot_ext[2:0];
	assign slot_last = (slot_q == SLOT_W'(NUM_TIMERS - 1));

	// per-slot decisions
	assign cnt_inc   = cnt_rd + 32'd1;
	assign tick_hit  = active_q[slot_q] && (cnt_inc >= per_rd);
	assign free_here = !active_q[slot_q];
	assign zero_per  = (period_q == 32'd0);
	assign scan_end  = zero_per || free_here || slot_last;
	assign claim     = (ctrl.op == OP_START) && !zero_per && free_here;

	// stop request decode: targets beyond the pool match nothing
	always_comb begin
		for (int i = 0; i < NUM_TIMERS; i++) begin
			stop_hit[i] = (i < NUM_SLOT_CODES) && (target_q == 3'(i));
		end
	end

	// storage writes
	assign cnt_we    = ((ctrl.op == OP_TICK) && active_q[slot_q]) || claim;
	assign cnt_wdata = (claim || tick_hit) ? 32'd0 : cnt_inc;
	assign cfg_we    = claim;

	mstp_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (slot_q),
		.wdata (cnt_wdata),
		.raddr (slot_q),
		.rdata (cnt_rd)
	);

	mstp_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS)) u_per_ram (
		.clk   (clk),
		.we    (cfg_we),
		.waddr (slot_q),
		.wdata (period_q),
		.raddr (slot_q),
		.rdata (per_rd)
	);

	mstp_ram #(.WIDTH(8), .DEPTH(NUM_TIMERS)) u_tag_ram (
		.clk   (clk),
		.we    (cfg_we),
		.waddr (slot_q),
		.wdata (tag_q),
		.raddr (slot_q),
		.rdata (tag_rd)
	);

	// result entry generation
	always_comb begin
		buf_we = 1'b0;
		buf_wd = '{status: ST_OK, slot: 3'd0, expired: 1'b0, tag: 8'd0};
		unique case (ctrl.op)
			OP_TICK: begin
				buf_we = tick_hit && (n_q < RES_CNT_W'(MAX_RES));
				buf_wd = '{status: ST_OK, slot: slot3, expired: 1'b1, tag: tag_rd};
			end
			OP_TICK_FIN: begin
				buf_we = (n_q == '0);
			end
			OP_START: begin
				buf_we = scan_end;
				if (zero_per) begin
					buf_wd.status = ST_ZERO;
				end else if (free_here) begin
					buf_wd.slot = slot3;
				end else begin
					buf_wd.status = ST_NOFREE;
				end
			end
			OP_STOP: begin
				buf_we      = 1'b1;
				buf_wd.slot = target_q;
			end
			OP_OTHER: begin
				buf_we = 1'b1;
			end
			default: begin
				buf_we = 1'b0;
			end
		endcase
	end

	// emit handshake
	assign buf_rd    = res_q[emit_q];
	assign emit_fire = (ctrl.op == OP_EMIT) && (!out_valid_q || !out_stall);
	assign emit_last = ({1'b0, emit_q} == (n_q - RES_CNT_W'(1)));

	// next step
	always_comb begin
		unique case (ctrl.cond)
			C_ALWAYS:    pc_d = ctrl.jmp;
			C_DISPATCH:  pc_d = in_fire ? dispatch(action) : ctrl.nxt;
			C_SLOT_LAST: pc_d = slot_last ? ctrl.jmp : ctrl.nxt;
			C_SCAN_END:  pc_d = scan_end ? ctrl.jmp : ctrl.nxt;
			C_EMIT_LAST: pc_d = (emit_fire && emit_last) ? ctrl.jmp : ctrl.nxt;
			default:     pc_d = S_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= S_IDLE;
			active_q    <= '0;
			repeat_q    <= '0;
			slot_q      <= '0;
			n_q         <= '0;
			emit_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_d;
			if (buf_we) begin
				n_q <= n_q + RES_CNT_W'(1);
			end
			unique case (ctrl.op)
				OP_IDLE: begin
					if (in_fire) begin
						slot_q <= '0;
						n_q    <= '0;
						emit_q <= '0;
					end
				end
				OP_TICK: begin
					if (tick_hit && !repeat_q[slot_q]) begin
						active_q[slot_q] <= 1'b0;
					end
					if (!slot_last) begin
						slot_q <= slot_q + SLOT_W'(1);
					end
				end
				OP_START: begin
					if (claim) begin
						active_q[slot_q] <= 1'b1;
						repeat_q[slot_q] <= rep_q;
					end else if (!scan_end) begin
						slot_q <= slot_q + SLOT_W'(1);
					end
				end
				OP_STOP: begin
					active_q <= active_q & ~stop_hit;
				end
				OP_EMIT: begin
					if (emit_fire) begin
						emit_q <= emit_q + RES_IDX_W'(1);
					end
				end
				default: begin
				end
			endcase
			// output valid
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			period_q <= period_ticks;
			rep_q    <= repeat_mode;
			tag_q    <= user_tag;
			target_q <= target_slot;
		end
		if (buf_we) begin
			res_q[n_q[RES_IDX_W-1:0]] <= buf_wd;
		end
		if (emit_fire) begin
			out_q  <= buf_rd;
			last_q <= emit_last;
			any_q  <= |active_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign slot_index  = out_q.slot;
	assign expired     = out_q.expired;
	assign expired_tag = out_q.tag;
	assign last_result = last_q;
	assign any_active  = any_q;

endmodule

`default_nettype wire

// ===== sv/mstp_chk.sv =====
// ---------------------------------------------------------------------------
// mstp_chk: port checks for the tick timer pool
// Watches the result channel and is bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mstp_chk
	import mstp_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [1:0] status,
	input wire logic [2:0] slot_index,
	input wire logic       expired,
	input wire logic [7:0] expired_tag,
	input wire logic       last_result,
	input wire logic       any_active
);

	// a stalled transfer holds its result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot_index)
			&& $stable(expired) && $stable(expired_tag) && $stable(last_result)
			&& $stable(any_active))
		else $error("stalled result changed");

	// expiry results always carry ok status
	a_exp_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && expired |-> status == ST_OK)
		else $error("expiry with error status");

	// non-expiry results stand alone
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !expired |-> last_result)
		else $error("non-expiry result not last");

	// failed starts report slot zero and no tag
	a_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_NOFREE || status == ST_ZERO)
			|-> slot_index == 3'd0 && !expired && expired_tag == 8'd0)
		else $error("failed start with slot or tag");

endmodule

bind multi_slot_tick_timer_pool_top mstp_chk u_mstp_chk (.*);

`default_nettype wire

// ===== verif/multi_slot_tick_timer_pool_top_tb.sv =====
// ---------------------------------------------------------------------------
// multi_slot_tick_timer_pool_top_tb: self-checking bench for the timer pool
// Drives tick, start, stop and unused requests, keeps its own copy of the
// slot table to predict every result, and compares each result transfer
// field by field while both handshakes idle and stall at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_slot_tick_timer_pool_top_tb;
	import mstp_pkg::*;

	localparam int          NUM_SLOTS    = 8;
	localparam int          LIMIT_CYCLES = 400000;
	localparam int          DRAIN_CYCLES = 40;
	localparam logic [1:0]  ACT_UNUSED   = 2'd3;
	localparam logic [31:0] PERIOD_MAX   = 32'hFFFF_FFFF;

	// one predicted result transfer
	typedef struct {
		logic [1:0] status;
		logic [2:0] slot;
		logic       expired;
		logic [7:0] tag;
		logic       last;
		logic       busy;
	} pool_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  action;
	logic [31:0] period_ticks;
	logic        repeat_mode;
	logic [7:0]  user_tag;
	logic [2:0]  target_slot;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [2:0]  slot_index;
	logic        expired;
	logic [7:0]  expired_tag;
	logic        last_result;
	logic        any_active;

	// predicted slot table
	logic [NUM_SLOTS-1:0] slot_on;
	logic [NUM_SLOTS-1:0] slot_rep;
	logic [31:0]          slot_per [NUM_SLOTS];
	logic [31:0]          slot_cnt [NUM_SLOTS];
	logic [7:0]           slot_id  [NUM_SLOTS];

	pool_result_t expected_results[$];

	int err_cnt     = 0;
	int cycles      = 0;
	int n_requests  = 0;
	int n_ticks     = 0;
	int n_starts    = 0;
	int n_stops     = 0;
	int n_unused    = 0;
	int n_expiries  = 0;
	int n_rejects   = 0;
	int n_checked   = 0;
	bit tx_idle_on  = 1'b1;
	bit rx_idle_on  = 1'b1;

	multi_slot_tick_timer_pool_top #(.NUM_TIMERS(NUM_SLOTS)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.period_ticks (period_ticks),
		.repeat_mode  (repeat_mode),
		.user_tag     (user_tag),
		.target_slot  (target_slot),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.slot_index   (slot_index),
		.expired      (expired),
		.expired_tag  (expired_tag),
		.last_result  (last_result),
		.any_active   (any_active)
	);

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				expected_results.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic report_err(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		err_cnt++;
	endtask

	// mostly short lengths, now and then a long one
	function automatic int pick_len();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	// advance the slot table by one request and queue the results it causes
	task automatic timer_pool_step(input logic [1:0] act, input logic [31:0] per,
		input logic rep, input logic [7:0] tag, input logic [2:0] tgt);
		pool_result_t res[$];
		pool_result_t r;
		pool_result_t blank;
		logic         busy;
		int           s;
		int           found;
		blank = '{status: ST_OK, slot: 3'd0, expired: 1'b0, tag: 8'd0, last: 1'b0,
			busy: 1'b0};
		r = blank;
		found = -1;
		n_requests++;
		case (act)
			ACT_TICK: begin
				n_ticks++;
				// every active slot counts; those reaching their period report
				for (s = 0; s < NUM_SLOTS; s++) begin
					if (slot_on[s]) begin
						slot_cnt[s] = slot_cnt[s] + 32'd1;
						if (slot_cnt[s] >= slot_per[s]) begin
							slot_cnt[s] = 32'd0;
							r = blank;
							r.slot = 3'(s);
							r.expired = 1'b1;
							r.tag = slot_id[s];
							res.push_back(r);
							n_expiries++;
							if (!slot_rep[s])
								slot_on[s] = 1'b0;
						end
					end
				end
				if (res.size() == 0)
					res.push_back(blank);
			end
			ACT_START: begin
				n_starts++;
				if (per == 32'd0) begin
					r.status = ST_ZERO;
					n_rejects++;
				end else begin
					// lowest free slot wins
					for (s = 0; s < NUM_SLOTS; s++) begin
						if (!slot_on[s] && found < 0)
							found = s;
					end
					if (found >= 0) begin
						slot_on[found] = 1'b1;
						slot_rep[found] = rep;
						slot_per[found] = per;
						slot_cnt[found] = 32'd0;
						slot_id[found] = tag;
						r.slot = 3'(found);
					end else begin
						r.status = ST_NOFREE;
						n_rejects++;
					end
				end
				res.push_back(r);
			end
			ACT_STOP: begin
				n_stops++;
				slot_on[tgt] = 1'b0;
				r.slot = tgt;
				res.push_back(r);
			end
			default: begin
				n_unused++;
				res.push_back(blank);
			end
		endcase
		busy = |slot_on;
		foreach (res[i]) begin
			res[i].busy = busy;
			res[i].last = (i == res.size() - 1);
			expected_results.push_back(res[i]);
		end
	endtask

	// send one request, holding it until the block takes the transfer
	task automatic send_req(input logic [1:0] act, input logic [31:0] per,
		input logic rep, input logic [7:0] tag, input logic [2:0] tgt);
		int gap;
		gap = 0;
		if (tx_idle_on && $urandom_range(0, 2) == 0)
			gap = pick_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		action       <= act;
		period_ticks <= per;
		repeat_mode  <= rep;
		user_tag     <= tag;
		target_slot  <= tgt;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		timer_pool_step(act, per, rep, tag, tgt);
	endtask

	// result side: check each transfer, then pick the next stall value
	int stall_left = 0;
	always @(posedge clk) begin : rx_side
		pool_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_err($sformatf("result with nothing expected: slot %0d exp %0d",
					slot_index, expired));
			end else begin
				want = expected_results.pop_front();
				n_checked++;
				if (status !== want.status)
					report_err($sformatf("status %0d, want %0d", status, want.status));
				if (slot_index !== want.slot)
					report_err($sformatf("slot_index %0d, want %0d", slot_index, want.slot));
				if (expired !== want.expired)
					report_err($sformatf("expired %0d, want %0d", expired, want.expired));
				if (expired_tag !== want.tag)
					report_err($sformatf("expired_tag %0h, want %0h", expired_tag, want.tag));
				if (last_result !== want.last)
					report_err($sformatf("last_result %0d, want %0d", last_result, want.last));
				if (any_active !== want.busy)
					report_err($sformatf("any_active %0d, want %0d", any_active, want.busy));
			end
		end
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
			out_stall <= 1'b1;
			stall_left = pick_len() - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// empty pool: plain tick, unused code, stop of an inactive slot
	task automatic test_idle_pool();
		send_req(ACT_TICK, 32'd0, 1'b0, 8'd0, 3'd0);
		send_req(ACT_UNUSED, PERIOD_MAX, 1'b1, 8'hFF, 3'd7);
		send_req(ACT_STOP, 32'd5, 1'b0, 8'h5A, 3'd7);
	endtask

	// zero period, fill every slot, then both rejects on a full pool
	task automatic test_fill_and_reject();
		int k;
		logic [7:0] tag;
		send_req(ACT_START, 32'd0, 1'b1, 8'h11, 3'd0);
		for (k = 0; k < NUM_SLOTS; k++) begin
			tag = (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'(k * 37);
			send_req(ACT_START, 32'd1, k[0], tag, 3'($urandom_range(0, 7)));
		end
		send_req(ACT_START, 32'd5, 1'b1, 8'h22, 3'd0);
		send_req(ACT_START, 32'd0, 1'b0, 8'h33, 3'd0);
	endtask

	// full expiry sweep, one-shots dropping out, stops and a long period
	task automatic test_expiry_and_stop();
		send_req(ACT_TICK, 32'd0, 1'b0, 8'd0, 3'd0);
		send_req(ACT_TICK, PERIOD_MAX, 1'b1, 8'hFF, 3'd7);
		send_req(ACT_STOP, 32'd0, 1'b0, 8'd0, 3'd1);
		send_req(ACT_STOP, 32'd0, 1'b0, 8'd0, 3'd3);
		send_req(ACT_STOP, 32'd0, 1'b0, 8'd0, 3'd5);
		send_req(ACT_TICK, 32'd0, 1'b0, 8'd0, 3'd0);
		send_req(ACT_STOP, 32'd0, 1'b0, 8'd0, 3'd7);
		send_req(ACT_START, PERIOD_MAX, 1'b1, 8'hA5, 3'd0);
		send_req(ACT_START, 32'd2, 1'b0, 8'h5A, 3'd0);
		send_req(ACT_TICK, 32'd0, 1'b0, 8'd0, 3'd0);
		send_req(ACT_TICK, 32'd0, 1'b0, 8'd0, 3'd0);
		send_req(ACT_STOP, 32'd0, 1'b0, 8'd0, 3'd0);
	endtask

	// mixed traffic; mostly short periods so expiries and a full pool recur
	task automatic test_random_traffic(input int count);
		int          i;
		int          pick;
		int          sel;
		logic [1:0]  act;
		logic [31:0] per;
		for (i = 0; i < count; i++) begin
			// opening stretch runs back to back on both sides
			tx_idle_on = (i >= 60);
			rx_idle_on = (i >= 60);
			pick = $urandom_range(0, 99);
			sel = $urandom_range(0, 19);
			if (sel < 14)
				per = $urandom_range(1, 8);
			else if (sel < 17)
				per = $urandom;
			else if (sel < 18)
				per = 32'd0;
			else
				per = PERIOD_MAX - $urandom_range(0, 3);
			if (pick < 45)
				act = ACT_TICK;
			else if (pick < 80)
				act = ACT_START;
			else if (pick < 95)
				act = ACT_STOP;
			else
				act = ACT_UNUSED;
			send_req(act, per, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
				3'($urandom_range(0, 7)));
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		action       = ACT_TICK;
		period_ticks = 32'd0;
		repeat_mode  = 1'b0;
		user_tag     = 8'd0;
		target_slot  = 3'd0;
		out_stall    = 1'b0;
		slot_on      = '0;
		slot_rep     = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_pool();
		test_fill_and_reject();
		test_expiry_and_stop();
		test_random_traffic(370);

		// drain outstanding results
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("coverage: %0d requests (%0d tick, %0d start, %0d stop, %0d unused code)",
			n_requests, n_ticks, n_starts, n_stops, n_unused);
		$display("coverage: %0d results checked, %0d expiries, %0d rejected starts",
			n_checked, n_expiries, n_rejects);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
